// ===== rtl/cstag_pkg.sv =====
// Package with the shared types, codes and constants of the coherent tag array.
`default_nettype none

package cstag_pkg;

    localparam int ADDR_W         = 32;
    localparam int TIME_W         = 32;
    localparam int DEF_SETS       = 64;
    localparam int DEF_WAYS       = 4;
    localparam int DEF_LINE_BYTES = 128;
    localparam int WAY_IDX_W      = 4;
    localparam int LINE_CALC_W    = 16;
    localparam int LINE_IDX_W     = 8;

    typedef logic [WAY_IDX_W-1:0] way_t;

    typedef enum logic [1:0] {
        OP_ACCESS     = 2'd0,
        OP_INVALIDATE = 2'd1,
        OP_FLUSH      = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        LS_INVALID  = 2'd0,
        LS_SHARED   = 2'd1,
        LS_MODIFIED = 2'd2
    } lstate_t;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_FILL        = 3'd1,
        ST_EVICT       = 3'd2,
        ST_INVALIDATED = 3'd3,
        ST_INV_MISS    = 3'd4,
        ST_FLUSHED     = 3'd5,
        ST_NO_VICTIM   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FLUSH,
        S_REPLY
    } fsm_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic              is_write;
        logic [TIME_W-1:0] timestamp;
    } in_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [LINE_IDX_W-1:0] line_index;
        logic [ADDR_W-1:0]     evicted_address;
        logic                  evicted_was_modified;
    } out_t;

    typedef struct packed {
        logic hit;
        way_t hit_way;
        logic free;
        way_t free_way;
        way_t victim_way;
    } sel_t;

endpackage

`default_nettype wire

// ===== rtl/cstag_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module cstag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cstag_select.sv =====
// Hit, free-way and victim selection over the ways of one set.
`default_nettype none

module cstag_select
    import cstag_pkg::*;
#(
    parameter int WAYS  = DEF_WAYS,
    parameter int BLK_W = 25
) (
    input  wire logic [WAYS-1:0][1:0]        way_state,
    input  wire logic [WAYS-1:0][BLK_W-1:0]  way_blk,
    input  wire logic [WAYS-1:0][TIME_W-1:0] way_time,
    input  wire logic [BLK_W-1:0]            block,
    output sel_t                             sel
);

    localparam int TREE_D = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int LEAVES = 1 << TREE_D;
    localparam int NODES  = 2 * LEAVES - 1;

    logic              node_ok   [NODES];
    logic [TIME_W-1:0] node_time [NODES];
    way_t              node_way  [NODES];

    always_comb begin
        sel = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_state[w] != LS_INVALID && way_blk[w] == block) begin
                sel.hit     = 1'b1;
                sel.hit_way = way_t'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (way_state[w] == LS_INVALID) begin
                sel.free     = 1'b1;
                sel.free_way = way_t'(w);
            end
        end

        for (int k = 0; k < LEAVES; k++) begin
            if (k < WAYS) begin
                node_ok[LEAVES-1+k]   = (way_state[k] != LS_INVALID);
                node_time[LEAVES-1+k] = way_time[k];
            end else begin
                node_ok[LEAVES-1+k]   = 1'b0;
                node_time[LEAVES-1+k] = '0;
            end
            node_way[LEAVES-1+k] = way_t'(k);
        end
        for (int i = LEAVES - 2; i >= 0; i--) begin
            if (node_ok[2*i+2] &&
                (!node_ok[2*i+1] || node_time[2*i+2] < node_time[2*i+1])) begin
                node_ok[i]   = 1'b1;
                node_time[i] = node_time[2*i+2];
                node_way[i]  = node_way[2*i+2];
            end else begin
                node_ok[i]   = node_ok[2*i+1];
                node_time[i] = node_time[2*i+1];
                node_way[i]  = node_way[2*i+1];
            end
        end
        sel.victim_way = node_way[0];
    end

endmodule

`default_nettype wire

// ===== rtl/coherent_set_assoc_tag_array_top.sv =====
// Top level of the coherent set-associative tag array.
// An accepted lookup request reads its set row; the lookup state registers its result once the
// output is free. A new request is taken only when idle: one set-row read of the tag RAM,
// then its write-back. A flush rewrites all SETS rows, one per cycle, then replies.
// After reset a clearing pass over all rows runs with s_ready low; the policy resets to LRU.
`default_nettype none

module coherent_set_assoc_tag_array_top
    import cstag_pkg::*;
#(
    parameter int SETS       = DEF_SETS,
    parameter int WAYS       = DEF_WAYS,
    parameter int LINE_BYTES = DEF_LINE_BYTES
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data
);

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int BLK_W = ADDR_W - OFF_W;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        lstate_t           state;
        logic [BLK_W-1:0]  blk;
        logic [TIME_W-1:0] last_use;
        logic [TIME_W-1:0] fill_time;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    fsm_t             state_reg, state_next;
    logic [SET_W-1:0] set_cnt_reg;
    in_t              req_reg;
    logic             policy_reg;
    logic             m_valid_reg;
    out_t             m_data_reg;

    logic             accept, out_free, sweep, last_row, lookup_go, load_out;
    logic             ram_rd_en, ram_wr_en;
    logic [SET_W-1:0] ram_rd_addr, ram_wr_addr;
    logic [ROW_W-1:0] ram_rd_data, ram_wr_data;

    logic [BLK_W-1:0] in_blk, req_blk;
    logic [SET_W-1:0] req_set;
    row_t             rd_row, new_row;
    sel_t             sel;
    logic             lookup_write;
    out_t             lookup_res, flush_res;
    logic [WAY_W-1:0] way;
    logic [LINE_CALC_W-1:0] line_full;

    logic [WAYS-1:0][1:0]        way_state;
    logic [WAYS-1:0][BLK_W-1:0]  way_blk;
    logic [WAYS-1:0][TIME_W-1:0] way_time;

    assign in_blk  = s_data.address[ADDR_W-1:OFF_W];
    assign req_blk = req_reg.address[ADDR_W-1:OFF_W];
    assign req_set = (SETS > 1) ? req_blk[SET_W-1:0] : '0;
    assign rd_row  = row_t'(ram_rd_data);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            way_state[w] = rd_row[w].state;
            way_blk[w]   = rd_row[w].blk;
            way_time[w]  = policy_reg ? rd_row[w].fill_time : rd_row[w].last_use;
        end
    end

    cstag_select #(
        .WAYS  (WAYS),
        .BLK_W (BLK_W)
    ) u_select (
        .way_state (way_state),
        .way_blk   (way_blk),
        .way_time  (way_time),
        .block     (req_blk),
        .sel       (sel)
    );

    cstag_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (last_row) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = s_data.operation[1] ? S_FLUSH : S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (last_row) begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == S_IDLE);
        accept      = s_valid && s_ready;
        out_free    = !m_valid_reg || m_ready;
        sweep       = (state_reg == S_CLEAR) || (state_reg == S_FLUSH);
        last_row    = (set_cnt_reg == SET_W'(SETS - 1));
        lookup_go   = (state_reg == S_LOOKUP) && out_free;
        ram_rd_en   = accept && !s_data.operation[1];
        ram_rd_addr = (SETS > 1) ? in_blk[SET_W-1:0] : '0;
        ram_wr_en   = sweep || (lookup_go && lookup_write);
        ram_wr_addr = sweep ? set_cnt_reg : req_set;
        ram_wr_data = sweep ? '0 : ROW_W'(new_row);
        load_out    = lookup_go || ((state_reg == S_REPLY) && out_free);
        cfg_ready   = 1'b1;
        m_valid     = m_valid_reg;
        m_data      = m_data_reg;
    end

    always_comb begin
        new_row      = rd_row;
        lookup_write = 1'b0;
        lookup_res   = '0;
        way          = '0;
        if (req_reg.operation == OP_INVALIDATE) begin
            if (sel.hit) begin
                way                = sel.hit_way[WAY_W-1:0];
                new_row[way].state = LS_INVALID;
                lookup_write       = 1'b1;
                lookup_res.status  = ST_INVALIDATED;
            end else begin
                lookup_res.status  = ST_INV_MISS;
            end
        end else if (sel.hit) begin
            way                   = sel.hit_way[WAY_W-1:0];
            new_row[way].last_use = req_reg.timestamp;
            if (req_reg.is_write) begin
                new_row[way].state = LS_MODIFIED;
            end
            lookup_write      = 1'b1;
            lookup_res.status = ST_HIT;
        end else begin
            if (sel.free) begin
                way               = sel.free_way[WAY_W-1:0];
                lookup_res.status = ST_FILL;
            end else begin
                way                             = sel.victim_way[WAY_W-1:0];
                lookup_res.status               = ST_EVICT;
                lookup_res.evicted_address      = {rd_row[way].blk, {OFF_W{1'b0}}};
                lookup_res.evicted_was_modified = (rd_row[way].state == LS_MODIFIED);
            end
            new_row[way].blk       = req_blk;
            new_row[way].state     = req_reg.is_write ? LS_MODIFIED : LS_SHARED;
            new_row[way].fill_time = req_reg.timestamp;
            new_row[way].last_use  = req_reg.timestamp;
            lookup_write           = 1'b1;
        end
        line_full = LINE_CALC_W'(req_set) * LINE_CALC_W'(WAYS) + LINE_CALC_W'(way);
        if (lookup_res.status != ST_INV_MISS) begin
            lookup_res.line_index = line_full[LINE_IDX_W-1:0];
        end
        flush_res        = '0;
        flush_res.status = ST_FLUSHED;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            set_cnt_reg <= '0;
            policy_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (sweep) begin
                set_cnt_reg <= last_row ? '0 : set_cnt_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready) begin
                policy_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (load_out) begin
            m_data_reg <= (state_reg == S_REPLY) ? flush_res : lookup_res;
        end
    end

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("Tag RAM read and write issued in the same cycle.");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("Pending result overwritten before it was taken.");

    a_lookup_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.operation[1]) |=> (state_reg == S_LOOKUP))
        else $error("Lookup request did not enter the lookup cycle.");

    a_flush_starts_at_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation[1]) |=> (set_cnt_reg == '0))
        else $error("Flush sweep did not start at the first row.");

    a_victim_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOOKUP) |->
        ({1'b0, sel.victim_way} < (WAY_IDX_W + 1)'(WAYS)))
        else $error("Victim way outside the set.");

endmodule

`default_nettype wire
